/* hw/rtl/sbss_pkg.sv */
// shared widths, constants and record types for the swept box segment test
`default_nettype none
package sbss_pkg;

  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DW         = COORD_BITS + 1;
  localparam int PW         = 2 * COORD_BITS;
  localparam int SW         = 2 * COORD_BITS + 6;
  localparam int LW         = 2 * COORD_BITS + 4;
  localparam int QW         = FRAC_BITS + 1;
  localparam int NSLAB      = 3;
  localparam int NLANE      = 2 * NSLAB;
  localparam int NST        = 5 + FRAC_BITS;

  localparam logic [QW-1:0] FONE = {1'b1, {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic signed [SW-1:0] p;
    logic signed [SW-1:0] d;
    logic signed [SW-1:0] lo;
    logic signed [SW-1:0] hi;
  } slab_t;

  typedef struct packed {
    logic signed [SW-1:0] na;
    logic signed [SW-1:0] nb;
    logic [LW-1:0]        den;
    logic                 dz;
    logic                 contain;
  } prep_t;

  typedef struct packed {
    logic [LW-1:0] rem;
    logic [LW-1:0] den;
    logic [QW-1:0] q;
    logic          sat;
  } lane_t;

  typedef struct packed {
    logic [NSLAB-1:0] bad;
    logic [NSLAB-1:0] dz;
  } flags_t;

endpackage
`default_nettype wire

/* hw/rtl/swept_box_segment_sat.sv */
// swept square against segment slab test, fully pipelined
// from accepted input word to valid result word, most stages are divider lanes
// throughput: one word per cycle, every stage takes a new word each unstalled cycle
// a stalled output freezes the whole pipeline, nothing is dropped or repeated
// reset (synchronous, active low) clears all stage valid bits and the output
// payload registers are not reset
`default_nettype none
module swept_box_segment_sat (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_valid,
  output logic                                         in_ready,
  input  wire logic signed [sbss_pkg::COORD_BITS-1:0]  in_center_x,
  input  wire logic signed [sbss_pkg::COORD_BITS-1:0]  in_center_y,
  input  wire logic signed [sbss_pkg::COORD_BITS-1:0]  in_move_x,
  input  wire logic signed [sbss_pkg::COORD_BITS-1:0]  in_move_y,
  input  wire logic        [sbss_pkg::COORD_BITS-2:0]  in_half_extent,
  input  wire logic signed [sbss_pkg::COORD_BITS-1:0]  in_seg_a_x,
  input  wire logic signed [sbss_pkg::COORD_BITS-1:0]  in_seg_a_y,
  input  wire logic signed [sbss_pkg::COORD_BITS-1:0]  in_seg_b_x,
  input  wire logic signed [sbss_pkg::COORD_BITS-1:0]  in_seg_b_y,
  output logic                                         out_valid,
  input  wire logic                                    out_ready,
  output logic                                         out_hit,
  output logic [sbss_pkg::QW-1:0]                      out_entry_fraction
);

  localparam int CB = sbss_pkg::COORD_BITS;
  localparam int DW = sbss_pkg::DW;
  localparam int PW = sbss_pkg::PW;
  localparam int SW = sbss_pkg::SW;
  localparam int LW = sbss_pkg::LW;
  localparam int QW = sbss_pkg::QW;
  localparam int FB = sbss_pkg::FRAC_BITS;
  localparam int NL = sbss_pkg::NLANE;
  localparam int NS = sbss_pkg::NSLAB;
  localparam int NST = sbss_pkg::NST;

  function automatic logic [CB-1:0] mag(input logic signed [DW-1:0] v);
    logic signed [DW-1:0] t;
    t = v[DW-1] ? -v : v;
    return t[CB-1:0];
  endfunction

  function automatic logic signed [SW-1:0] sterm(input logic [PW-1:0] m, input logic neg);
    logic signed [SW-1:0] t;
    t = $signed(SW'(m));
    return neg ? -t : t;
  endfunction

  function automatic sbss_pkg::prep_t slab_prep(input sbss_pkg::slab_t s);
    sbss_pkg::prep_t r;
    logic signed [SW-1:0] dn;
    r.dz      = (s.d == '0);
    r.contain = (s.lo <= s.p) && (s.p <= s.hi);
    if (s.d < 0) begin
      r.na = s.p - s.hi;
      r.nb = s.p - s.lo;
      dn   = -s.d;
    end else begin
      r.na = s.lo - s.p;
      r.nb = s.hi - s.p;
      dn   = s.d;
    end
    r.den = dn[LW-1:0];
    return r;
  endfunction

  function automatic sbss_pkg::lane_t lane_init(input logic signed [SW-1:0] n,
                                                input logic [LW-1:0] den);
    sbss_pkg::lane_t l;
    l.q = '0;
    if (n <= 0) begin
      l.rem = '0;
      l.den = LW'(1);
      l.sat = 1'b0;
    end else if ($signed(SW'(den)) <= n) begin
      l.rem = '0;
      l.den = LW'(1);
      l.sat = 1'b1;
    end else begin
      l.rem = n[LW-1:0];
      l.den = den;
      l.sat = 1'b0;
    end
    return l;
  endfunction

  function automatic sbss_pkg::lane_t lane_step(input sbss_pkg::lane_t l);
    sbss_pkg::lane_t r;
    logic [LW:0] t;
    logic        b;
    t = {l.rem, 1'b0};
    b = (t >= {1'b0, l.den});
    if (b) t = t - {1'b0, l.den};
    r.rem = t[LW-1:0];
    r.den = l.den;
    r.q   = {l.q[QW-2:0], b};
    r.sat = l.sat;
    return r;
  endfunction

  function automatic logic [QW-1:0] lane_val(input sbss_pkg::lane_t l);
    return l.sat ? sbss_pkg::FONE : l.q;
  endfunction

  logic adv;
  logic [NST-1:0] vld_r, vld_nxt;

  // stage 1: differences and axis slabs
  logic signed [DW-1:0] s1_rx_r, s1_ry_r, s1_nx_r, s1_ny_r, s1_mx_r, s1_my_r;
  logic signed [DW-1:0] s1_rx_nxt, s1_ry_nxt, s1_nx_nxt, s1_ny_nxt, s1_mx_nxt, s1_my_nxt;
  logic [CB-2:0]        s1_h_r, s1_h_nxt;
  sbss_pkg::slab_t      s1_sx_r, s1_sy_r, s1_sx_nxt, s1_sy_nxt;
  logic signed [DW-1:0] ex_w, ey_w;

  // stage 2: magnitude products
  logic [PW-1:0]   s2_m_r [4];
  logic [PW-1:0]   s2_m_nxt [4];
  logic [3:0]      s2_neg_r, s2_neg_nxt;
  logic [PW-1:0]   s2_pad_r, s2_pad_nxt;
  sbss_pkg::slab_t s2_sx_r, s2_sy_r;

  // stage 3: normal axis slab
  sbss_pkg::slab_t s3_s_r [NS];
  sbss_pkg::slab_t s3_s_nxt [NS];

  // stage 4: slab numerators
  sbss_pkg::prep_t s4_p_r [NS];
  sbss_pkg::prep_t s4_p_nxt [NS];

  // divider lanes
  sbss_pkg::lane_t dv_r [FB+1][NL];
  sbss_pkg::lane_t dv_nxt [FB+1][NL];
  sbss_pkg::flags_t fl_r [FB+1];
  sbss_pkg::flags_t fl_nxt;

  logic          out_valid_r, out_valid_nxt, out_hit_r, out_hit_nxt;
  logic [QW-1:0] out_frac_r, out_frac_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    vld_nxt = {vld_r[NST-2:0], in_valid};
    out_valid_nxt = vld_r[NST-1];
  end

  always_comb begin
    s1_rx_nxt = DW'(in_center_x) - DW'(in_seg_a_x);
    s1_ry_nxt = DW'(in_center_y) - DW'(in_seg_a_y);
    ex_w      = DW'(in_seg_b_x) - DW'(in_seg_a_x);
    ey_w      = DW'(in_seg_b_y) - DW'(in_seg_a_y);
    s1_nx_nxt = -ey_w;
    s1_ny_nxt = ex_w;
    s1_mx_nxt = DW'(in_move_x);
    s1_my_nxt = DW'(in_move_y);
    s1_h_nxt  = in_half_extent;
    s1_sx_nxt.p  = SW'(s1_rx_nxt);
    s1_sx_nxt.d  = SW'(in_move_x);
    s1_sx_nxt.lo = (ex_w < 0 ? SW'(ex_w) : '0) - $signed(SW'(in_half_extent));
    s1_sx_nxt.hi = (ex_w < 0 ? '0 : SW'(ex_w)) + $signed(SW'(in_half_extent));
    s1_sy_nxt.p  = SW'(s1_ry_nxt);
    s1_sy_nxt.d  = SW'(in_move_y);
    s1_sy_nxt.lo = (ey_w < 0 ? SW'(ey_w) : '0) - $signed(SW'(in_half_extent));
    s1_sy_nxt.hi = (ey_w < 0 ? '0 : SW'(ey_w)) + $signed(SW'(in_half_extent));
  end

  always_comb begin
    s2_m_nxt[0] = PW'(mag(s1_rx_r)) * PW'(mag(s1_nx_r));
    s2_m_nxt[1] = PW'(mag(s1_ry_r)) * PW'(mag(s1_ny_r));
    s2_m_nxt[2] = PW'(mag(s1_mx_r)) * PW'(mag(s1_nx_r));
    s2_m_nxt[3] = PW'(mag(s1_my_r)) * PW'(mag(s1_ny_r));
    s2_neg_nxt  = {s1_my_r[DW-1] ^ s1_ny_r[DW-1], s1_mx_r[DW-1] ^ s1_nx_r[DW-1],
                   s1_ry_r[DW-1] ^ s1_ny_r[DW-1], s1_rx_r[DW-1] ^ s1_nx_r[DW-1]};
    s2_pad_nxt  = PW'(s1_h_r) * PW'({1'b0, mag(s1_nx_r)} + {1'b0, mag(s1_ny_r)});
  end

  always_comb begin
    s3_s_nxt[0]    = s2_sx_r;
    s3_s_nxt[1]    = s2_sy_r;
    s3_s_nxt[2].p  = sterm(s2_m_r[0], s2_neg_r[0]) + sterm(s2_m_r[1], s2_neg_r[1]);
    s3_s_nxt[2].d  = sterm(s2_m_r[2], s2_neg_r[2]) + sterm(s2_m_r[3], s2_neg_r[3]);
    s3_s_nxt[2].lo = sterm(s2_pad_r, 1'b1);
    s3_s_nxt[2].hi = sterm(s2_pad_r, 1'b0);
  end

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      s4_p_nxt[i] = slab_prep(s3_s_r[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      dv_nxt[0][2*i]   = lane_init(s4_p_r[i].na, s4_p_r[i].den);
      dv_nxt[0][2*i+1] = lane_init(s4_p_r[i].nb, s4_p_r[i].den);
      fl_nxt.dz[i]     = s4_p_r[i].dz;
      fl_nxt.bad[i]    = s4_p_r[i].dz ? !s4_p_r[i].contain :
                         (($signed(SW'(s4_p_r[i].den)) < s4_p_r[i].na) ||
                          (s4_p_r[i].nb < 0));
    end
    for (int k = 1; k <= FB; k++) begin
      for (int j = 0; j < NL; j++) begin
        dv_nxt[k][j] = lane_step(dv_r[k-1][j]);
      end
    end
  end

  always_comb begin
    logic [QW-1:0] ent, ext, qa, qb;
    ent = '0;
    ext = sbss_pkg::FONE;
    for (int i = 0; i < NS; i++) begin
      qa = fl_r[FB].dz[i] ? '0 : lane_val(dv_r[FB][2*i]);
      qb = fl_r[FB].dz[i] ? sbss_pkg::FONE : lane_val(dv_r[FB][2*i+1]);
      if (qa > ent) ent = qa;
      if (qb < ext) ext = qb;
    end
    out_hit_nxt  = !(|fl_r[FB].bad) && (ent <= ext);
    out_frac_nxt = out_hit_nxt ? ent : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rx_r  <= s1_rx_nxt;
      s1_ry_r  <= s1_ry_nxt;
      s1_nx_r  <= s1_nx_nxt;
      s1_ny_r  <= s1_ny_nxt;
      s1_mx_r  <= s1_mx_nxt;
      s1_my_r  <= s1_my_nxt;
      s1_h_r   <= s1_h_nxt;
      s1_sx_r  <= s1_sx_nxt;
      s1_sy_r  <= s1_sy_nxt;
      s2_m_r   <= s2_m_nxt;
      s2_neg_r <= s2_neg_nxt;
      s2_pad_r <= s2_pad_nxt;
      s2_sx_r  <= s1_sx_r;
      s2_sy_r  <= s1_sy_r;
      s3_s_r   <= s3_s_nxt;
      s4_p_r   <= s4_p_nxt;
      dv_r     <= dv_nxt;
      fl_r[0]  <= fl_nxt;
      for (int k = 1; k <= FB; k++) begin
        fl_r[k] <= fl_r[k-1];
      end
      out_hit_r  <= out_hit_nxt;
      out_frac_r <= out_frac_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_entry_fraction = out_frac_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_frac_r == '0)
    else $error("miss with nonzero fraction");

  a_frac_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_frac_r <= sbss_pkg::FONE)
    else $error("fraction above one");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input blocked with empty output");

endmodule
`default_nettype wire
